// ----- hdl/pfa_pkg.sv -----
// pfa_pkg: shared types, codes and widths for the paged frame allocator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package pfa_pkg;

  // Fixed field widths of the ports
  localparam int OP_W      = 2;
  localparam int PID_W     = 4;
  localparam int SIZE_W    = 19;
  localparam int PAGE_W    = 6;
  localparam int ST_W      = 2;
  localparam int FRAME_W   = 8;
  localparam int COUNT_W   = 7;
  localparam int PS_W      = 13;
  localparam int FC_W      = 9;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;

  // Default storage sizes
  localparam int NUM_FRAMES_DEF         = 256;
  localparam int MAX_PROCS_DEF          = 16;
  localparam int MAX_PAGES_PER_PROC_DEF = 64;

  // Frame map is scanned one chunk of frames per cycle; the scan stays on a chunk while it still yields a free frame
  localparam int SCAN_W  = 16;
  localparam int SCAN_IW = 4;

  localparam logic [PS_W-1:0] PAGE_SIZE_RST   = 13'd256;
  localparam logic [PS_W-1:0] PAGE_SIZE_MAX   = 13'd4096;
  localparam logic [FC_W-1:0] FRAME_COUNT_RST = 9'd256;

  // Operations
  localparam logic [OP_W-1:0] OP_CREATE    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE    = 2'd1;
  localparam logic [OP_W-1:0] OP_RESIZE    = 2'd2;
  localparam logic [OP_W-1:0] OP_TRANSLATE = 2'd3;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_NOFRAME  = 2'd1;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_SIZE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 1'b1;

  // Controller -> datapath commands
  typedef struct packed {
    logic load_in;
    logic open_op;
    logic fail;
    logic tgt_zero;
    logic start_div;
    logic tgt_div;
    logic shrink_step;
    logic grow_reset;
    logic grow_step;
    logic no_frame;
    logic commit;
    logic xlate;
    logic out_load;
  } pfa_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            pid_ok;
    logic            present;
    logic            div_done;
    logic            have_gt;
    logic            have_lt;
    logic            free_pend;
    logic            grow_end;
  } pfa_sts_t;

  // Lowest set bit of a scan chunk
  function automatic logic [SCAN_IW-1:0] first_one(input logic [SCAN_W-1:0] v);
    logic [SCAN_IW-1:0] idx;
    idx = '0;
    for (int i = SCAN_W - 1; i >= 0; i--) begin
      if (v[i]) idx = SCAN_IW'(i);
    end
    return idx;
  endfunction

endpackage

// ----- hdl/paged_frame_allocator_top.sv -----
// Paged frame allocator: keeps a used mark per physical frame and a page table
// per process, and serves create, remove, resize and translate requests one at
// a time. A request is taken only while the block is idle; its result word sits
// in an output register, so the next request can be taken while that word still
// waits. A translate passes through decode, a page table read and the result
// step; a failed request goes from decode straight to the result. Create and remove
// release n pages, one page table read per cycle. Resize runs the bit-serial
// page-count divider, then adds or releases one page at a time, the first-fit scan
// stepping past a 16-frame chunk per cycle while it has no free frame (up to NUM_FRAMES/16).
// Depends on pfa_pkg, pfa_ctrl, pfa_dp, pfa_div.
`timescale 1ns / 1ps

module paged_frame_allocator_top
  import pfa_pkg::*;
#(
  parameter int NUM_FRAMES         = NUM_FRAMES_DEF,
  parameter int MAX_PROCS          = MAX_PROCS_DEF,
  parameter int MAX_PAGES_PER_PROC = MAX_PAGES_PER_PROC_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OP_W-1:0]      in_operation,
  input  logic [PID_W-1:0]     in_process_id,
  input  logic [SIZE_W-1:0]    in_size_bytes,
  input  logic [PAGE_W-1:0]    in_page_number,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ST_W-1:0]      out_status,
  output logic [FRAME_W-1:0]   out_frame_number,
  output logic [COUNT_W-1:0]   out_page_count,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  pfa_cmd_t cmd;
  pfa_sts_t sts;

  pfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  pfa_dp #(
    .NUM_FRAMES         (NUM_FRAMES),
    .MAX_PROCS          (MAX_PROCS),
    .MAX_PAGES_PER_PROC (MAX_PAGES_PER_PROC)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_operation     (in_operation),
    .in_process_id    (in_process_id),
    .in_size_bytes    (in_size_bytes),
    .in_page_number   (in_page_number),
    .out_status       (out_status),
    .out_frame_number (out_frame_number),
    .out_page_count   (out_page_count),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

endmodule

// ----- hdl/pfa_div.sv -----
// pfa_div: iterative restoring divider, one quotient bit per cycle.
// Gives the page count quotient and a nonzero-remainder flag. Uses pfa_pkg.
`timescale 1ns / 1ps

module pfa_div
  import pfa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SIZE_W-1:0] dividend,
  input  logic [PS_W-1:0]   divisor,
  output logic              done,
  output logic [SIZE_W-1:0] quotient,
  output logic              rem_nz
);

  localparam int DCW = $clog2(SIZE_W + 1);

  logic [DCW-1:0]    cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [PS_W:0]     rem_r;
  logic [SIZE_W-1:0] quo_r;
  logic [PS_W-1:0]   dvs_r;

  logic [PS_W:0]     shifted;
  logic              fits;

  assign shifted = {rem_r[PS_W-1:0], quo_r[SIZE_W-1]};
  assign fits    = shifted >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCW'(SIZE_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DCW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[SIZE_W-2:0], fits};
      rem_r <= fits ? (shifted - {1'b0, dvs_r}) : shifted;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;
  assign rem_nz   = rem_r != '0;

endmodule

// ----- hdl/pfa_dp.sv -----
// pfa_dp: allocator datapath: frame used bits, page table memory, page counts,
// config registers, chunked free-frame scan and result registers. Uses pfa_pkg, pfa_div.
`timescale 1ns / 1ps

module pfa_dp
  import pfa_pkg::*;
#(
  parameter int NUM_FRAMES         = NUM_FRAMES_DEF,
  parameter int MAX_PROCS          = MAX_PROCS_DEF,
  parameter int MAX_PAGES_PER_PROC = MAX_PAGES_PER_PROC_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pfa_cmd_t             cmd,
  output pfa_sts_t             sts,
  input  logic [OP_W-1:0]      in_operation,
  input  logic [PID_W-1:0]     in_process_id,
  input  logic [SIZE_W-1:0]    in_size_bytes,
  input  logic [PAGE_W-1:0]    in_page_number,
  output logic [ST_W-1:0]      out_status,
  output logic [FRAME_W-1:0]   out_frame_number,
  output logic [COUNT_W-1:0]   out_page_count,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int NCH       = (NUM_FRAMES + SCAN_W - 1) / SCAN_W;
  localparam int CIW       = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int FXW       = CIW + SCAN_IW;
  localparam int LIMW      = FXW + 1;
  localparam int CW        = $clog2(MAX_PAGES_PER_PROC + 1);
  localparam int PIW       = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int MEM_DEPTH = MAX_PROCS * MAX_PAGES_PER_PROC;
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int DVW       = SIZE_W + 1;

  // latched request
  logic [OP_W-1:0]   op_r;
  logic [PID_W-1:0]  pid_r;
  logic [SIZE_W-1:0] bytes_r;
  logic [PAGE_W-1:0] page_r;

  // working state
  logic [CW-1:0]   have_r;
  logic [CW-1:0]   tgt_r;
  logic [ST_W-1:0] stat_r;
  logic [CIW-1:0]  cur_r;
  logic            rd_free_r;

  // per-process and per-frame state
  logic [SCAN_W-1:0] used_r    [NCH];
  logic              present_r [MAX_PROCS];
  logic [CW-1:0]     pages_r   [MAX_PROCS];

  logic [FXW-1:0] map_mem [MEM_DEPTH];
  logic [FXW-1:0] rd_data_r;

  logic [PS_W-1:0] page_size_r;
  logic [FC_W-1:0] frame_count_r;

  logic [ST_W-1:0]    res_status_r;
  logic [FRAME_W-1:0] res_frame_r;
  logic [COUNT_W-1:0] res_count_r;
  logic [ST_W-1:0]    out_status_r;
  logic [FRAME_W-1:0] out_frame_r;
  logic [COUNT_W-1:0] out_count_r;

  logic [PIW-1:0]     pid_idx;
  logic               pid_ok;
  logic [PS_W-1:0]    eff_ps;
  logic [LIMW-1:0]    lim;
  logic [AW-1:0]      base_addr;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic               wr_en;
  logic [SCAN_W-1:0]  used_chunk;
  logic [SCAN_W-1:0]  avail;
  logic               hit;
  logic [SCAN_IW-1:0] alloc_bit;
  logic [LIMW-1:0]    next_base;
  logic [CIW-1:0]     free_ch;
  logic [SCAN_IW-1:0] free_bit;
  logic               free_ok;
  logic               tr_ok;
  logic               div_done;
  logic [SIZE_W-1:0]  div_q;
  logic               div_rnz;
  logic [DVW-1:0]     want;
  logic               too_many;

  assign pid_idx = PIW'(pid_r);
  assign pid_ok  = 32'(pid_r) < MAX_PROCS;

  // clamped register values
  always_comb begin
    if (page_size_r == '0) eff_ps = PS_W'(1);
    else if (page_size_r > PAGE_SIZE_MAX) eff_ps = PAGE_SIZE_MAX;
    else eff_ps = page_size_r;

    if (frame_count_r == '0) lim = LIMW'(1);
    else if (32'(frame_count_r) > NUM_FRAMES) lim = LIMW'(NUM_FRAMES);
    else lim = LIMW'(frame_count_r);
  end

  // first-fit scan over the current chunk, frames at or above the limit masked
  assign used_chunk = used_r[cur_r];
  always_comb begin
    for (int k = 0; k < SCAN_W; k++) begin
      avail[k] = !used_chunk[k] && ({1'b0, cur_r, SCAN_IW'(k)} < lim);
    end
  end
  assign hit       = avail != '0;
  assign alloc_bit = first_one(avail);
  assign next_base = (LIMW'(cur_r) + LIMW'(1)) << SCAN_IW;

  assign free_ch  = rd_data_r[FXW-1:SCAN_IW];
  assign free_bit = rd_data_r[SCAN_IW-1:0];
  assign free_ok  = 32'(rd_data_r) < NUM_FRAMES;

  assign tr_ok = (32'(page_r) < 32'(have_r)) && (32'(page_r) < MAX_PAGES_PER_PROC);

  // page table addressing
  assign base_addr = AW'(pid_idx) * AW'(MAX_PAGES_PER_PROC);
  assign rd_addr   = cmd.shrink_step ? (base_addr + AW'(have_r - 1'b1))
                                     : (base_addr + AW'(page_r));
  assign wr_addr   = base_addr + AW'(have_r);
  assign wr_en     = cmd.grow_step && hit;

  always_ff @(posedge clk) begin
    if (wr_en) map_mem[wr_addr] <= {cur_r, alloc_bit};
    rd_data_r <= map_mem[rd_addr];
  end

  pfa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.start_div),
    .dividend (bytes_r),
    .divisor  (eff_ps),
    .done     (div_done),
    .quotient (div_q),
    .rem_nz   (div_rnz)
  );

  // ceil of size over page size, capped at the table length
  assign want     = DVW'(div_q) + DVW'(div_rnz);
  assign too_many = want > DVW'(MAX_PAGES_PER_PROC);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_size_r   <= PAGE_SIZE_RST;
      frame_count_r <= FRAME_COUNT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PAGE_SIZE:   page_size_r   <= cfg_data[PS_W-1:0];
        REG_FRAME_COUNT: frame_count_r <= cfg_data[FC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= '{default: '0};
      present_r <= '{default: 1'b0};
      pages_r   <= '{default: '0};
      have_r    <= '0;
      tgt_r     <= '0;
      stat_r    <= ST_OK;
      cur_r     <= '0;
      rd_free_r <= 1'b0;
    end else begin
      rd_free_r <= cmd.shrink_step;
      if (cmd.open_op) have_r <= pages_r[pid_idx];
      if (cmd.tgt_zero) begin
        tgt_r  <= '0;
        stat_r <= ST_OK;
      end
      if (cmd.tgt_div) begin
        tgt_r  <= too_many ? CW'(MAX_PAGES_PER_PROC) : CW'(want);
        stat_r <= too_many ? ST_NOFRAME : ST_OK;
      end
      if (cmd.shrink_step) have_r <= have_r - 1'b1;
      // frame read in the previous cycle is released now
      if (rd_free_r && free_ok) used_r[free_ch][free_bit] <= 1'b0;
      if (cmd.grow_reset) cur_r <= '0;
      if (cmd.grow_step) begin
        if (hit) begin
          used_r[cur_r][alloc_bit] <= 1'b1;
          have_r <= have_r + 1'b1;
        end else begin
          cur_r <= cur_r + 1'b1;
        end
      end
      if (cmd.commit) begin
        pages_r[pid_idx]   <= have_r;
        present_r[pid_idx] <= op_r != OP_REMOVE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r    <= in_operation;
      pid_r   <= in_process_id;
      bytes_r <= in_size_bytes;
      page_r  <= in_page_number;
    end
    if (cmd.fail) begin
      res_status_r <= ST_NOTFOUND;
      res_frame_r  <= '0;
      res_count_r  <= '0;
    end
    // create and remove commit with have_r already walked down to zero
    if (cmd.commit) begin
      res_status_r <= cmd.no_frame ? ST_NOFRAME : stat_r;
      res_frame_r  <= '0;
      res_count_r  <= COUNT_W'(have_r);
    end
    if (cmd.xlate) begin
      res_status_r <= tr_ok ? ST_OK : ST_NOTFOUND;
      res_frame_r  <= tr_ok ? FRAME_W'(rd_data_r) : '0;
      res_count_r  <= COUNT_W'(have_r);
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_frame_r  <= res_frame_r;
      out_count_r  <= res_count_r;
    end
  end

  assign sts.op        = op_r;
  assign sts.pid_ok    = pid_ok;
  assign sts.present   = present_r[pid_idx];
  assign sts.div_done  = div_done;
  assign sts.have_gt   = have_r > tgt_r;
  assign sts.have_lt   = have_r < tgt_r;
  assign sts.free_pend = rd_free_r;
  assign sts.grow_end  = !hit && (next_base >= lim);

  assign out_status       = out_status_r;
  assign out_frame_number = out_frame_r;
  assign out_page_count   = out_count_r;

endmodule

// ----- hdl/pfa_ctrl.sv -----
// pfa_ctrl: request sequencer of the paged frame allocator.
// Drives datapath commands from its status; owns the handshakes. Uses pfa_pkg.
`timescale 1ns / 1ps

module pfa_ctrl
  import pfa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  pfa_sts_t sts,
  output pfa_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_SHRINK,
    S_GROW,
    S_XLATE,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.open_op = 1'b1;
        if (!sts.pid_ok) begin
          cmd.fail  = 1'b1;
          state_nxt = S_DONE;
        end else if (sts.op == OP_CREATE) begin
          cmd.tgt_zero = 1'b1;
          state_nxt    = S_SHRINK;
        end else if (!sts.present) begin
          cmd.fail  = 1'b1;
          state_nxt = S_DONE;
        end else if (sts.op == OP_REMOVE) begin
          cmd.tgt_zero = 1'b1;
          state_nxt    = S_SHRINK;
        end else if (sts.op == OP_RESIZE) begin
          cmd.start_div = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_XLATE;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.tgt_div = 1'b1;
          state_nxt   = S_SHRINK;
        end
      end
      S_SHRINK: begin
        if (sts.have_gt) begin
          cmd.shrink_step = 1'b1;
        end else if (!sts.free_pend) begin
          if (sts.op == OP_RESIZE) begin
            cmd.grow_reset = 1'b1;
            state_nxt      = S_GROW;
          end else begin
            cmd.commit = 1'b1;
            state_nxt  = S_DONE;
          end
        end
      end
      S_GROW: begin
        if (!sts.have_lt) begin
          cmd.commit = 1'b1;
          state_nxt  = S_DONE;
        end else if (sts.grow_end) begin
          cmd.no_frame = 1'b1;
          cmd.commit   = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          cmd.grow_step = 1'b1;
        end
      end
      S_XLATE: begin
        cmd.xlate = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

endmodule

// ----- hdl/pfa_checker.sv -----
// pfa_checker: port-level assertions for the paged frame allocator, and the
// bind that attaches them to paged_frame_allocator_top. Uses pfa_pkg.
`timescale 1ns / 1ps

module pfa_checker
  import pfa_pkg::*;
#(
  parameter int MAX_PAGES_PER_PROC = MAX_PAGES_PER_PROC_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [ST_W-1:0]    out_status,
  input logic [FRAME_W-1:0] out_frame_number,
  input logic [COUNT_W-1:0] out_page_count
);

  // a word held back by the sink stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_frame_number) && $stable(out_page_count))
    else $error("result word changed while stalled");

  // one request in flight: the input closes right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in flight");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_OK || out_status == ST_NOFRAME
      || out_status == ST_NOTFOUND)
    else $error("undefined status code");

  a_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_frame_number == '0)
    else $error("frame number set on a failed request");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_page_count) <= MAX_PAGES_PER_PROC)
    else $error("page count above table length");

endmodule

bind paged_frame_allocator_top pfa_checker #(
  .MAX_PAGES_PER_PROC (MAX_PAGES_PER_PROC)
) u_pfa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_status       (out_status),
  .out_frame_number (out_frame_number),
  .out_page_count   (out_page_count)
);
